// ===== sv/three_body_gravity_accel_core_macros.svh =====
// ----------------------------------------------------------------------------
// three_body_gravity_accel_core_macros
// Assertion macros shared by the gravity acceleration core
// ----------------------------------------------------------------------------
`ifndef THREE_BODY_GRAVITY_ACCEL_CORE_MACROS_SVH
`define THREE_BODY_GRAVITY_ACCEL_CORE_MACROS_SVH

// clocked property, masked while in reset
`define TBGA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition that must never be seen at a clock edge
`define TBGA_ASSERT_NEVER(label, cond, msg) \
  `TBGA_ASSERT(label, !(cond), msg)

`endif

// ===== sv/tbga_pkg.sv =====
// ----------------------------------------------------------------------------
// tbga_pkg
// Widths, latencies and shared types of the gravity acceleration core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tbga_pkg;

  localparam int AXES    = 3;
  localparam int BODIES  = 3;
  localparam int PAIRS   = 3;
  localparam int POS_W   = 32;
  localparam int MU_W    = 32;
  localparam int ACC_W   = 32;
  localparam int ROOT_W  = 32;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int NUM_W   = 63;
  localparam int DEN_W   = 64;
  localparam int QUO_W   = 32;
  localparam int SUM_W   = QUO_W + 2;
  localparam int IDX_W   = 2;

  // difference, square, sum, root pipe, product, r cubed, quotient pipe
  localparam int LANE_LAT = 3 + ROOT_W + 2 + QUO_W;
  // plus the merge register
  localparam int CORE_LAT = LANE_LAT + 1;

  typedef logic [AXES-1:0][POS_W-1:0] vec_t;

  typedef enum logic [IDX_W-1:0] {
    REG_MU_FIRST  = 2'd0,
    REG_MU_SECOND = 2'd1,
    REG_MU_THIRD  = 2'd2
  } reg_idx_t;

  // what one pair lane hands to the merge stage
  typedef struct packed {
    logic [AXES-1:0][QUO_W-1:0] q_i;
    logic [AXES-1:0][QUO_W-1:0] q_j;
    logic [AXES-1:0]            neg;
    logic                       coin;
  } lane_res_t;

endpackage

// ===== sv/tbga_isqrt.sv =====
// ----------------------------------------------------------------------------
// tbga_isqrt
// Pipelined floor square root, one result bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbga_isqrt (
  input  logic                        clk,
  input  logic [tbga_pkg::RAD_W-1:0]  rad,
  output logic [tbga_pkg::ROOT_W-1:0] root
);

  localparam int RW = tbga_pkg::ROOT_W;
  localparam int AW = tbga_pkg::RAD_W;
  localparam int TW = AW + 2;

  logic [AW-1:0] rem_q  [RW];
  logic [RW-1:0] root_q [RW];

  for (genvar s = 0; s < RW; s++) begin : g_stage
    localparam int B = RW - 1 - s;
    logic [AW-1:0] rem_in;
    logic [RW-1:0] root_in;
    logic [TW-1:0] trial;

    if (s == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    // (y + 2^b)^2 - y^2 = y * 2^(b+1) + 2^(2b)
    assign trial = (TW'(root_in) << (B + 1)) + (TW'(1) << (2 * B));

    // keep the bit when the remainder covers the trial step
    always_ff @(posedge clk) begin
      if ({2'b00, rem_in} >= trial) begin
        rem_q[s]  <= rem_in - trial[AW-1:0];
        root_q[s] <= root_in | (RW'(1) << B);
      end else begin
        rem_q[s]  <= rem_in;
        root_q[s] <= root_in;
      end
    end
  end

  assign root = root_q[RW-1];

endmodule

// ===== sv/tbga_div.sv =====
// ----------------------------------------------------------------------------
// tbga_div
// Pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbga_div (
  input  logic                       clk,
  input  logic [tbga_pkg::NUM_W-1:0] num,
  input  logic [tbga_pkg::DEN_W-1:0] den,
  output logic [tbga_pkg::QUO_W-1:0] quo
);

  localparam int NW = tbga_pkg::NUM_W;
  localparam int DW = tbga_pkg::DEN_W;
  localparam int QW = tbga_pkg::QUO_W;

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] low_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    localparam int B = QW - 1 - s;
    logic [DW-1:0] rem_in;
    logic [QW-1:0] low_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [DW:0]   part;

    // quotient is known to fit, so the top bits start below the divisor
    if (s == 0) begin : g_first
      assign rem_in = DW'(num[NW-1:QW]);
      assign low_in = num[QW-1:0];
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign den_in = den_q[s-1];
      assign quo_in = quo_q[s-1];
    end

    assign part = {rem_in, low_in[B]};

    // subtract the divisor where it fits
    always_ff @(posedge clk) begin
      low_q[s] <= low_in;
      den_q[s] <= den_in;
      if (part >= {1'b0, den_in}) begin
        rem_q[s] <= DW'(part - {1'b0, den_in});
        quo_q[s] <= quo_in | (QW'(1) << B);
      end else begin
        rem_q[s] <= part[DW-1:0];
        quo_q[s] <= quo_in;
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

// ===== sv/tbga_lane.sv =====
// ----------------------------------------------------------------------------
// tbga_lane
// One body pair: separation, r cubed and both scaled quotients per axis
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tbga_lane (
  input  logic                      clk,
  input  tbga_pkg::vec_t            pos_i,
  input  tbga_pkg::vec_t            pos_j,
  input  logic [tbga_pkg::MU_W-1:0] mu_i,
  input  logic [tbga_pkg::MU_W-1:0] mu_j,
  output tbga_pkg::lane_res_t       res
);

  localparam int AX = tbga_pkg::AXES;
  localparam int PW = tbga_pkg::POS_W;
  localparam int AW = tbga_pkg::RAD_W;
  localparam int RW = tbga_pkg::ROOT_W;
  localparam int NW = tbga_pkg::NUM_W;
  localparam int DW = tbga_pkg::DEN_W;
  localparam int QW = tbga_pkg::QUO_W;
  localparam int PRW = tbga_pkg::MU_W + PW;

  typedef struct packed {
    logic [AW-1:0]          d2;
    logic [AX-1:0][PW-1:0]  mag;
    logic [AX-1:0]          neg;
  } side_t;

  typedef struct packed {
    logic [AX-1:0] neg;
    logic          coin;
    logic          fits;
  } tail_t;

  logic [AX-1:0][PW-1:0] diff;
  logic [AX-1:0][PW-1:0] s1_mag;
  logic [AX-1:0]         s1_neg;
  logic [AX-1:0][AW-1:0] s2_sq;
  logic [AX-1:0][PW-1:0] s2_mag;
  logic [AX-1:0]         s2_neg;
  logic [AW-1:0]         s3_d2;
  logic [AX-1:0][PW-1:0] s3_mag;
  logic [AX-1:0]         s3_neg;
  side_t                 side_q [RW];
  logic [RW-1:0]         root;
  logic [AW-1:0]         s4_lo;
  logic [AW-1:0]         s4_hi;
  logic [AX-1:0][NW-1:0] s4_num_i;
  logic [AX-1:0][NW-1:0] s4_num_j;
  logic [AX-1:0]         s4_neg;
  logic                  s4_coin;
  logic [AW:0]           r3_sum;
  logic [DW-1:0]         s5_r3;
  logic                  s5_fits;
  logic [AX-1:0][NW-1:0] s5_num_i;
  logic [AX-1:0][NW-1:0] s5_num_j;
  logic [AX-1:0]         s5_neg;
  logic                  s5_coin;
  tail_t                 tail_q [QW];
  logic [AX-1:0][QW-1:0] quo_i;
  logic [AX-1:0][QW-1:0] quo_j;

  // wrapped per-axis difference
  always_comb begin
    for (int k = 0; k < AX; k++) begin
      diff[k] = pos_j[k] - pos_i[k];
    end
  end

  // magnitude, squares and squared distance
  always_ff @(posedge clk) begin
    for (int k = 0; k < AX; k++) begin
      s1_neg[k] <= diff[k][PW-1];
      s1_mag[k] <= diff[k][PW-1] ? (PW'(0) - diff[k]) : diff[k];
      s2_sq[k]  <= AW'(s1_mag[k]) * AW'(s1_mag[k]);
    end
    s2_mag <= s1_mag;
    s2_neg <= s1_neg;
    s3_d2  <= s2_sq[0] + s2_sq[1] + s2_sq[2];
    s3_mag <= s2_mag;
    s3_neg <= s2_neg;
  end

  tbga_isqrt u_isqrt (
    .clk  (clk),
    .rad  (s3_d2),
    .root (root)
  );

  // side data follows the root pipe
  always_ff @(posedge clk) begin
    side_q[0] <= '{d2: s3_d2, mag: s3_mag, neg: s3_neg};
    for (int i = 1; i < RW; i++) begin
      side_q[i] <= side_q[i-1];
    end
  end

  // partial products of r cubed and the mu numerators
  always_ff @(posedge clk) begin
    s4_lo <= AW'(side_q[RW-1].d2[RW-1:0]) * AW'(root);
    s4_hi <= AW'(side_q[RW-1].d2[AW-1:RW]) * AW'(root);
    for (int k = 0; k < AX; k++) begin
      s4_num_i[k] <= NW'(PRW'(mu_j) * PRW'(side_q[RW-1].mag[k]));
      s4_num_j[k] <= NW'(PRW'(mu_i) * PRW'(side_q[RW-1].mag[k]));
    end
    s4_neg  <= side_q[RW-1].neg;
    s4_coin <= (side_q[RW-1].d2 == '0);
  end

  // r cubed, with a flag for products beyond 64 bits
  assign r3_sum = {1'b0, s4_lo} + {1'b0, s4_hi[RW-1:0], {RW{1'b0}}};

  always_ff @(posedge clk) begin
    s5_r3    <= r3_sum[DW-1:0];
    s5_fits  <= (s4_hi[AW-1:RW] == '0) && !r3_sum[AW];
    s5_num_i <= s4_num_i;
    s5_num_j <= s4_num_j;
    s5_neg   <= s4_neg;
    s5_coin  <= s4_coin;
  end

  for (genvar k = 0; k < AX; k++) begin : g_axis
    tbga_div u_div_i (
      .clk (clk),
      .num (s5_num_i[k]),
      .den (s5_r3),
      .quo (quo_i[k])
    );

    tbga_div u_div_j (
      .clk (clk),
      .num (s5_num_j[k]),
      .den (s5_r3),
      .quo (quo_j[k])
    );
  end

  // flags follow the quotient pipe
  always_ff @(posedge clk) begin
    tail_q[0] <= '{neg: s5_neg, coin: s5_coin, fits: s5_fits};
    for (int i = 1; i < QW; i++) begin
      tail_q[i] <= tail_q[i-1];
    end
  end

  // skipped or out-of-range pairs contribute nothing
  always_comb begin
    res.neg  = tail_q[QW-1].neg;
    res.coin = tail_q[QW-1].coin;
    for (int k = 0; k < AX; k++) begin
      if (tail_q[QW-1].fits && !tail_q[QW-1].coin) begin
        res.q_i[k] = quo_i[k];
        res.q_j[k] = quo_j[k];
      end else begin
        res.q_i[k] = '0;
        res.q_j[k] = '0;
      end
    end
  end

endmodule

// ===== sv/three_body_gravity_accel_core.sv =====
// Results appear after start is taken, strobed by done.
// Throughput: one transaction per cycle; busy stays low.
// Depth is set by the 32-stage square root pipe and the 32-stage quotient pipe.
// Reset clears the in-flight strobes and the three mu registers.
// The receiver cannot stall: each result is held on the ports until the next result replaces it.
// ----------------------------------------------------------------------------
// three_body_gravity_accel_core
// Pairwise gravitational acceleration of three bodies, three pair lanes
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "three_body_gravity_accel_core_macros.svh"

module three_body_gravity_accel_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic                       wr_en,
  input  logic [tbga_pkg::IDX_W-1:0] wr_index,
  input  logic [tbga_pkg::MU_W-1:0]  wr_data,
  input  logic signed [31:0]         first_x,
  input  logic signed [31:0]         first_y,
  input  logic signed [31:0]         first_z,
  input  logic signed [31:0]         second_x,
  input  logic signed [31:0]         second_y,
  input  logic signed [31:0]         second_z,
  input  logic signed [31:0]         third_x,
  input  logic signed [31:0]         third_y,
  input  logic signed [31:0]         third_z,
  output logic                       done,
  output logic signed [31:0]         first_ax,
  output logic signed [31:0]         first_ay,
  output logic signed [31:0]         first_az,
  output logic signed [31:0]         second_ax,
  output logic signed [31:0]         second_ay,
  output logic signed [31:0]         second_az,
  output logic signed [31:0]         third_ax,
  output logic signed [31:0]         third_ay,
  output logic signed [31:0]         third_az,
  output logic                       coincident,
  output logic                       saturated
);

  localparam int AX  = tbga_pkg::AXES;
  localparam int NB  = tbga_pkg::BODIES;
  localparam int NP  = tbga_pkg::PAIRS;
  localparam int SW  = tbga_pkg::SUM_W;
  localparam int QW  = tbga_pkg::QUO_W;
  localparam int OW  = tbga_pkg::ACC_W;
  localparam int LL  = tbga_pkg::LANE_LAT;
  localparam int CL  = tbga_pkg::CORE_LAT;
  localparam logic signed [SW-1:0] SUM_MAX = SW'((64'sd1 <<< (OW - 1)) - 64'sd1);
  localparam logic signed [SW-1:0] SUM_MIN = -SW'(64'sd1 <<< (OW - 1));
  localparam logic signed [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
  localparam logic signed [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

  logic [tbga_pkg::MU_W-1:0] mu [NB];
  tbga_pkg::vec_t            pos [NB];
  tbga_pkg::lane_res_t       lres [NP];
  logic [CL-1:0]             vld;
  logic signed [SW-1:0]      acc_sum [NB][AX];
  logic signed [OW-1:0]      acc_next [NB][AX];
  logic                      sat_next;
  logic                      coin_next;
  logic signed [OW-1:0]      acc_q [NB][AX];
  logic                      coin_q;
  logic                      sat_q;
  logic                      any_rail;

  function automatic logic signed [SW-1:0] signed_q(input logic [QW-1:0] q,
                                                    input logic negate);
    logic signed [SW-1:0] v;
    v = $signed({2'b00, q});
    return negate ? -v : v;
  endfunction

  // every cycle can take a transaction
  assign busy = 1'b0;

  // configuration register write decode
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int b = 0; b < NB; b++) begin
        mu[b] <= '0;
      end
    end else if (wr_en) begin
      unique case (tbga_pkg::reg_idx_t'(wr_index))
        tbga_pkg::REG_MU_FIRST:  mu[0] <= wr_data;
        tbga_pkg::REG_MU_SECOND: mu[1] <= wr_data;
        tbga_pkg::REG_MU_THIRD:  mu[2] <= wr_data;
        default: ;
      endcase
    end
  end

  assign pos[0] = {first_z, first_y, first_x};
  assign pos[1] = {second_z, second_y, second_x};
  assign pos[2] = {third_z, third_y, third_x};

  // pair lanes: first-second, first-third, second-third
  tbga_lane u_lane_12 (
    .clk (clk), .pos_i (pos[0]), .pos_j (pos[1]),
    .mu_i (mu[0]), .mu_j (mu[1]), .res (lres[0])
  );

  tbga_lane u_lane_13 (
    .clk (clk), .pos_i (pos[0]), .pos_j (pos[2]),
    .mu_i (mu[0]), .mu_j (mu[2]), .res (lres[1])
  );

  tbga_lane u_lane_23 (
    .clk (clk), .pos_i (pos[1]), .pos_j (pos[2]),
    .mu_i (mu[1]), .mu_j (mu[2]), .res (lres[2])
  );

  // transaction valid line alongside the lanes
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[CL-2:0], start && !busy};
    end
  end

  // merge: two contributions per body and axis, then clamp
  always_comb begin
    sat_next  = 1'b0;
    coin_next = lres[0].coin || lres[1].coin || lres[2].coin;
    for (int k = 0; k < AX; k++) begin
      acc_sum[0][k] = signed_q(lres[0].q_i[k], lres[0].neg[k])
                    + signed_q(lres[1].q_i[k], lres[1].neg[k]);
      acc_sum[1][k] = signed_q(lres[0].q_j[k], !lres[0].neg[k])
                    + signed_q(lres[2].q_i[k], lres[2].neg[k]);
      acc_sum[2][k] = signed_q(lres[1].q_j[k], !lres[1].neg[k])
                    + signed_q(lres[2].q_j[k], !lres[2].neg[k]);
    end
    for (int b = 0; b < NB; b++) begin
      for (int k = 0; k < AX; k++) begin
        if (acc_sum[b][k] > SUM_MAX) begin
          acc_next[b][k] = OUT_MAX;
          sat_next       = 1'b1;
        end else if (acc_sum[b][k] < SUM_MIN) begin
          acc_next[b][k] = OUT_MIN;
          sat_next       = 1'b1;
        end else begin
          acc_next[b][k] = acc_sum[b][k][OW-1:0];
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (vld[LL-1]) begin
      acc_q  <= acc_next;
      coin_q <= coin_next;
      sat_q  <= sat_next;
    end
  end

  assign done       = vld[CL-1];
  assign first_ax   = acc_q[0][0];
  assign first_ay   = acc_q[0][1];
  assign first_az   = acc_q[0][2];
  assign second_ax  = acc_q[1][0];
  assign second_ay  = acc_q[1][1];
  assign second_az  = acc_q[1][2];
  assign third_ax   = acc_q[2][0];
  assign third_ay   = acc_q[2][1];
  assign third_az   = acc_q[2][2];
  assign coincident = coin_q;
  assign saturated  = sat_q;

  // some output sits on a rail
  always_comb begin
    any_rail = 1'b0;
    for (int b = 0; b < NB; b++) begin
      for (int k = 0; k < AX; k++) begin
        if (acc_q[b][k] == OUT_MAX || acc_q[b][k] == OUT_MIN) begin
          any_rail = 1'b1;
        end
      end
    end
  end

  `TBGA_ASSERT(a_latency, start && !busy |-> ##70 done, "result strobe missing after transaction")
  `TBGA_ASSERT(a_no_spurious, done |-> $past(start && !busy, 70), "result strobe without transaction")
  `TBGA_ASSERT_NEVER(a_sat_rail, done && saturated && !any_rail, "saturation flag with no clamped value")

endmodule
